FILE: hw/rtl/sthc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthc_pkg
// Shared types and constants of the spectrum threshold hit counter.
// ----------------------------------------------------------------------------
package sthc_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int POINTS_DEF      = 4096;
    localparam int LINES_DEF       = 3;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int REQ_W       = 2;
    localparam int LINE_W      = 2;
    localparam int POINT_W     = 12;
    localparam int LEVEL_W     = 16;
    localparam int HIT_COUNT_W = 16;
    localparam int SWEEP_W     = 32;
    localparam int CFG_W       = 3;

    // Only this many lines take part in the comparison (width of line_enable).
    localparam int CMP_LINES_MAX = 3;

    // Threshold level after reset: 100 dB in 1/16 dB steps.
    localparam logic [LEVEL_W-1:0] THRESH_RESET = 16'd1600;

    // Request kinds.
    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_LINE_ENABLE = 1'b0,
        CFG_AND_LOGIC   = 1'b1
    } cfg_idx_t;

    // Status of the memory sweep sequencer.
    typedef struct packed {
        logic active;   // a sweep is writing the memories
        logic init;     // sweep after reset: thresholds are written as well
    } sweep_ctl_t;

    // Decision of the evaluation stage.
    typedef struct packed {
        logic       hit;
        logic [1:0] exceeded;
        logic       cnt_we;
    } eval_res_t;

endpackage

FILE: hw/rtl/sthc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sthc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sthc_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthc_sweep
// Address sequencer that walks every frequency point once, one per cycle.
// It runs after reset (threshold and counter initialisation) and after a
// clear request (counters only).
// ----------------------------------------------------------------------------
module sthc_sweep #(
    parameter int POINTS = sthc_pkg::POINTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start_clear,
    output sthc_pkg::sweep_ctl_t      ctl,
    output logic [$clog2(POINTS)-1:0] addr
);

    localparam int PW = $clog2(POINTS);
    localparam logic [PW-1:0] LAST_ADDR = PW'(POINTS - 1);

    sthc_pkg::sweep_ctl_t ctl_reg;
    sthc_pkg::sweep_ctl_t ctl_next;
    logic [PW-1:0]        addr_reg;
    logic [PW-1:0]        addr_next;

    // Next-state logic of the sweep.
    always_comb
    begin
        ctl_next  = ctl_reg;
        addr_next = addr_reg;
        if (start_clear)
        begin
            ctl_next.active = 1'b1;
            ctl_next.init   = 1'b0;
            addr_next       = '0;
        end
        else if (ctl_reg.active)
        begin
            addr_next = addr_reg + 1'b1;
            if (addr_reg == LAST_ADDR)
            begin
                ctl_next.active = 1'b0;
                ctl_next.init   = 1'b0;
                addr_next       = '0;
            end
        end
    end

    // Reset starts the initialisation sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.active <= 1'b1;
            ctl_reg.init   <= 1'b1;
            addr_reg       <= '0;
        end
        else
        begin
            ctl_reg  <= ctl_next;
            addr_reg <= addr_next;
        end
    end

    assign ctl  = ctl_reg;
    assign addr = addr_reg;

endmodule

FILE: hw/rtl/sthc_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthc_eval
// Evaluation stage: compares a sample against the enabled threshold lines,
// forms the hit decision and the updated point counter and sweep count.
// ----------------------------------------------------------------------------
module sthc_eval #(
    parameter int LINES_USED  = sthc_pkg::CMP_LINES_MAX,
    parameter int COUNT_WIDTH = sthc_pkg::COUNT_WIDTH_DEF
) (
    input  logic [sthc_pkg::REQ_W-1:0]                     req,
    input  logic                                           point_ok,
    input  logic [sthc_pkg::LEVEL_W-1:0]                   level,
    input  logic                                           last,
    input  logic [LINES_USED-1:0][sthc_pkg::LEVEL_W-1:0]   thr,
    input  logic [COUNT_WIDTH-1:0]                         cnt,
    input  logic [sthc_pkg::CFG_W-1:0]                     line_enable,
    input  logic                                           and_logic,
    input  logic [sthc_pkg::SWEEP_W-1:0]                   sweep_count,
    output sthc_pkg::eval_res_t                            res,
    output logic [COUNT_WIDTH-1:0]                         cnt_new,
    output logic [sthc_pkg::HIT_COUNT_W-1:0]               hit_count,
    output logic [sthc_pkg::SWEEP_W-1:0]                   sweep_next
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [LINES_USED-1:0] en_mask;
    logic [LINES_USED-1:0] exc_mask;
    logic [1:0]            exc_cnt;
    logic                  active;
    logic                  hit;
    logic [31:0]           cnt_wide;

    // Per-line strict signed comparison.
    always_comb
    begin
        exc_cnt = '0;
        for (int l = 0; l < LINES_USED; l++)
        begin
            en_mask[l]  = line_enable[l];
            exc_mask[l] = line_enable[l] && ($signed(level) > $signed(thr[l]));
            exc_cnt     = exc_cnt + 2'(exc_mask[l]);
        end
    end

    // Hit decision, counter update and sweep count.
    always_comb
    begin
        active     = (req == sthc_pkg::REQ_SAMPLE) && (|en_mask) && point_ok;
        hit        = 1'b0;
        cnt_new    = cnt;
        sweep_next = sweep_count;
        if (active)
        begin
            if (and_logic)
            begin
                hit = (exc_mask == en_mask);
            end
            else
            begin
                hit = |exc_mask;
            end
            if (hit && (cnt != CNT_MAX))
            begin
                cnt_new = cnt + 1'b1;
            end
            if (last && (sweep_count != '1))
            begin
                sweep_next = sweep_count + 1'b1;
            end
        end
        if (req == sthc_pkg::REQ_CLEAR)
        begin
            sweep_next = '0;
        end
        res.hit      = hit;
        res.exceeded = active ? exc_cnt : 2'd0;
        res.cnt_we   = active && hit;
    end

    // Reported counter: low bits of the point counter after the step, zero for an out-of-range point or a clear.
    always_comb
    begin
        cnt_wide = 32'(cnt_new);
        if (!point_ok || (req == sthc_pkg::REQ_CLEAR))
        begin
            hit_count = '0;
        end
        else
        begin
            hit_count = cnt_wide[sthc_pkg::HIT_COUNT_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/spectrum_threshold_hit_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_threshold_hit_counter
// Spectrum occupancy detector: threshold lines and saturating hit counters
// per frequency point, held in synchronous RAMs.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while its input is ready and
// returns exactly one result per request (RAM read, then the evaluation stage
// that writes the point counter back, then the output register).
// Each threshold line and the counter array are single-read,
// single-write RAMs; a counter written back by one request is forwarded to a
// request for the same point that follows directly. After reset the input is
// not ready while a pass writes the reset level of 100 dB into every
// threshold entry and zero into every counter. A clear request is answered
// like any other, and the input then stays not ready while the counters are
// zeroed. Configuration writes are taken at any time but should only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module spectrum_threshold_hit_counter #(
    parameter int POINTS      = sthc_pkg::POINTS_DEF,
    parameter int LINES       = sthc_pkg::LINES_DEF,
    parameter int COUNT_WIDTH = sthc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[1:0], line_index[3:2], point_index[15:4], level[31:16]
    input  logic [31:0] s_tdata,
    // last_of_sweep
    input  logic        s_tlast,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit[0], lines_exceeded[2:1], hit_count[18:3], sweep_count[50:19], zero fill
    output logic [55:0] m_tdata,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data
);

    localparam int PW         = $clog2(POINTS);
    localparam int LINES_USED = (LINES < sthc_pkg::CMP_LINES_MAX) ?
                                LINES : sthc_pkg::CMP_LINES_MAX;
    localparam int LW         = sthc_pkg::LEVEL_W;
    localparam int SW         = sthc_pkg::SWEEP_W;

    // Request fields.
    logic [sthc_pkg::REQ_W-1:0]   in_req;
    logic [sthc_pkg::LINE_W-1:0]  in_line;
    logic [sthc_pkg::POINT_W-1:0] in_point;
    logic [LW-1:0]                in_level;
    logic [31:0]                  in_point_wide;
    logic [PW-1:0]                in_addr;
    logic                         in_point_ok;
    logic                         s_accept;

    // Configuration registers.
    logic [sthc_pkg::CFG_W-1:0] line_enable_reg;
    logic                       and_logic_reg;

    // Evaluation stage registers.
    logic                       s1_valid_reg;
    logic [sthc_pkg::REQ_W-1:0] s1_req_reg;
    logic                       s1_point_ok_reg;
    logic [LW-1:0]              s1_level_reg;
    logic                       s1_last_reg;
    logic [PW-1:0]              s1_addr_reg;
    logic                       s1_adv;

    // Counter forwarding.
    logic                   fwd_valid_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;
    logic                   fwd_valid_next;

    // Sweep count and output register.
    logic [SW-1:0] sweep_count_reg;
    logic          out_valid_reg;
    logic [55:0]   out_data_reg;
    logic [55:0]   out_data_next;

    // Memory ports.
    logic [LINES_USED-1:0][LW-1:0] thr_rd;
    logic [COUNT_WIDTH-1:0]        cnt_rd;
    logic [COUNT_WIDTH-1:0]        cnt_cur;
    logic                          cnt_we;
    logic [PW-1:0]                 cnt_waddr;
    logic [COUNT_WIDTH-1:0]        cnt_wdata;

    // Sweep sequencer.
    sthc_pkg::sweep_ctl_t sweep_ctl;
    logic [PW-1:0]        sweep_addr;
    logic                 start_clear;

    // Evaluation results.
    sthc_pkg::eval_res_t              ev_res;
    logic [COUNT_WIDTH-1:0]           ev_cnt_new;
    logic [sthc_pkg::HIT_COUNT_W-1:0] ev_hit_count;
    logic [SW-1:0]                    ev_sweep_next;

    // Field extraction and point range check.
    assign in_req        = s_tdata[1:0];
    assign in_line       = s_tdata[3:2];
    assign in_point      = s_tdata[15:4];
    assign in_level      = s_tdata[31:16];
    assign in_point_wide = 32'(in_point);
    assign in_addr       = in_point_wide[PW-1:0];
    assign in_point_ok   = in_point_wide < 32'(POINTS);

    // Handshake: the evaluation stage moves on when the output register frees.
    assign s1_adv      = !out_valid_reg || m_tready;
    assign s_tready    = !sweep_ctl.active && (!s1_valid_reg || s1_adv);
    assign s_accept    = s_tvalid && s_tready;
    assign start_clear = s_accept && (in_req == sthc_pkg::REQ_CLEAR);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_enable_reg <= '0;
            and_logic_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sthc_pkg::CFG_LINE_ENABLE: line_enable_reg <= cfg_data;
                sthc_pkg::CFG_AND_LOGIC:   and_logic_reg   <= cfg_data[0];
                default:                   and_logic_reg   <= and_logic_reg;
            endcase
        end
    end

    // Initialisation and clear sequencer.
    sthc_sweep #(
        .POINTS (POINTS)
    ) u_sweep (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_clear (start_clear),
        .ctl         (sweep_ctl),
        .addr        (sweep_addr)
    );

    // Threshold line memories; loads are written as they are accepted.
    for (genvar l = 0; l < LINES_USED; l++)
    begin : g_thr
        logic          thr_we;
        logic [PW-1:0] thr_waddr;
        logic [LW-1:0] thr_wdata;

        assign thr_we    = (sweep_ctl.active && sweep_ctl.init) ||
                           (s_accept && (in_req == sthc_pkg::REQ_LOAD) &&
                            in_point_ok && (in_line == sthc_pkg::LINE_W'(l)));
        assign thr_waddr = sweep_ctl.active ? sweep_addr : in_addr;
        assign thr_wdata = sweep_ctl.active ? sthc_pkg::THRESH_RESET : in_level;

        sthc_ram #(
            .WIDTH (LW),
            .DEPTH (POINTS)
        ) u_thr_ram (
            .clk   (clk),
            .we    (thr_we),
            .waddr (thr_waddr),
            .wdata (thr_wdata),
            .re    (s_accept),
            .raddr (in_addr),
            .rdata (thr_rd[l])
        );
    end

    // Counter memory: written back by the evaluation stage or the sweep.
    assign cnt_we    = sweep_ctl.active || (s1_valid_reg && s1_adv && ev_res.cnt_we);
    assign cnt_waddr = sweep_ctl.active ? sweep_addr : s1_addr_reg;
    assign cnt_wdata = sweep_ctl.active ? '0 : ev_cnt_new;

    sthc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (POINTS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (s_accept),
        .raddr (in_addr),
        .rdata (cnt_rd)
    );

    // A request that reads the point being written back in the same cycle
    // takes the written value instead of the stale RAM data.
    assign fwd_valid_next = s1_valid_reg && s1_adv && ev_res.cnt_we &&
                            (s1_addr_reg == in_addr);
    assign cnt_cur        = fwd_valid_reg ? fwd_data_reg : cnt_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            fwd_data_reg <= ev_cnt_new;
        end
    end

    // Evaluation stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Evaluation stage payload.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_req_reg      <= in_req;
            s1_point_ok_reg <= in_point_ok;
            s1_level_reg    <= in_level;
            s1_last_reg     <= s_tlast;
            s1_addr_reg     <= in_addr;
        end
    end

    sthc_eval #(
        .LINES_USED  (LINES_USED),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_eval (
        .req         (s1_req_reg),
        .point_ok    (s1_point_ok_reg),
        .level       (s1_level_reg),
        .last        (s1_last_reg),
        .thr         (thr_rd),
        .cnt         (cnt_cur),
        .line_enable (line_enable_reg),
        .and_logic   (and_logic_reg),
        .sweep_count (sweep_count_reg),
        .res         (ev_res),
        .cnt_new     (ev_cnt_new),
        .hit_count   (ev_hit_count),
        .sweep_next  (ev_sweep_next)
    );

    // Completed sweep count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_count_reg <= '0;
        end
        else if (s1_valid_reg && s1_adv)
        begin
            sweep_count_reg <= ev_sweep_next;
        end
    end

    // Output register.
    assign out_data_next = {5'd0, ev_sweep_next, ev_hit_count, ev_res.exceeded, ev_res.hit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // No request enters while a sweep owns the memories.
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_ctl.active |-> !s_tready)
        else $error("request accepted during memory sweep");

    // A clear request starts the counter sweep in the next cycle.
    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (in_req == sthc_pkg::REQ_CLEAR)) |=> sweep_ctl.active)
        else $error("clear request did not start counter sweep");

    // The evaluation stage never writes a counter while the sweep runs.
    a_no_wb_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_ctl.active |-> !(s1_valid_reg && ev_res.cnt_we))
        else $error("counter write-back collides with sweep");

endmodule

FILE: test/tb_spectrum_threshold_hit_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_threshold_hit_counter
// Self-checking testbench for the spectrum threshold hit counter.
// ----------------------------------------------------------------------------
// A short directed plan covers the behaviour at reset, strict comparison at
// the threshold, the extremes of the level range, out-of-range line loads,
// samples with no line enabled, OR and AND modes, and a clear. Random phases
// follow, each under its own register setting: mostly sweeps over
// neighbouring points with levels near the stored thresholds, mixed with
// loads, reads, clears, broken sweeps and noise. Every result is compared
// against an in-house model of the thresholds, counters and sweep count (or a
// typed-in value for checked directed rows), while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_spectrum_threshold_hit_counter;

    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 190;
    localparam int MAX_CLEARS    = 20;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    // One request as it travels on the input stream.
    typedef struct packed {
        logic                                last;
        logic signed [sthc_pkg::LEVEL_W-1:0] level;
        logic [sthc_pkg::POINT_W-1:0]        point;
        logic [sthc_pkg::LINE_W-1:0]         line;
        sthc_pkg::req_t                      kind;
    } occ_req_t;

    // One result, laid out as in the result stream.
    typedef struct packed {
        logic [sthc_pkg::SWEEP_W-1:0]     sweeps;
        logic [sthc_pkg::HIT_COUNT_W-1:0] count;
        logic [1:0]                       exceeded;
        logic                             hit;
    } occ_result_t;

    // One row of the directed plan: either a register setting or a request.
    typedef struct packed {
        logic         cfg_row;
        logic [2:0]   en;
        logic         and_on;
        occ_req_t     rq;
        logic         golden_on;
        occ_result_t  golden;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [2:0]  cfg_data;

    // Model of the block's state and registers.
    logic signed [sthc_pkg::LEVEL_W-1:0] thr_lines [sthc_pkg::LINES_DEF][sthc_pkg::POINTS_DEF];
    logic [sthc_pkg::HIT_COUNT_W-1:0]    hit_counts [sthc_pkg::POINTS_DEF];
    logic [sthc_pkg::SWEEP_W-1:0]        sweep_total;
    logic [2:0]                          en_mask;
    logic                                and_mode;

    occ_result_t expected_results [$];
    plan_row_t   directed_plan [$];

    int fail_count;
    int results_checked;
    int items_counted;
    int clears_sent;
    int clears_left;
    int settings_applied;
    logic [sthc_pkg::POINT_W-1:0] hot_base;

    logic [2:0] fixed_en  [6] = '{3'd7, 3'd0, 3'd7, 3'd1, 3'd4, 3'd3};
    logic       fixed_and [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    spectrum_threshold_hit_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #(50_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // Works out the result of one request and updates the model state.
    function automatic occ_result_t predict_occupancy(input occ_req_t rq);
        occ_result_t res;
        int enabled;
        int over;
        res = '0;
        enabled = 0;
        over = 0;
        case (rq.kind)
            sthc_pkg::REQ_SAMPLE:
            begin
                for (int l = 0; l < sthc_pkg::LINES_DEF && l < sthc_pkg::CMP_LINES_MAX; l++)
                begin
                    if (en_mask[l])
                    begin
                        enabled++;
                        if ($signed(rq.level) > $signed(thr_lines[l][rq.point]))
                            over++;
                    end
                end
                // With no line enabled the sample changes nothing.
                if (enabled != 0)
                begin
                    res.hit = and_mode ? (over == enabled) : (over != 0);
                    res.exceeded = (over > 3) ? 2'd3 : 2'(over);
                    if (res.hit && hit_counts[rq.point] != '1)
                        hit_counts[rq.point] = hit_counts[rq.point] + 1'b1;
                    if (rq.last && sweep_total != '1)
                        sweep_total = sweep_total + 1'b1;
                end
            end
            sthc_pkg::REQ_LOAD:
            begin
                if (rq.line < sthc_pkg::LINES_DEF)
                    thr_lines[rq.line][rq.point] = rq.level;
            end
            sthc_pkg::REQ_CLEAR:
            begin
                foreach (hit_counts[i])
                    hit_counts[i] = '0;
                sweep_total = '0;
            end
            default:
            begin
            end
        endcase
        res.count = hit_counts[rq.point];
        res.sweeps = sweep_total;
        return res;
    endfunction

    function automatic plan_row_t req_row(input sthc_pkg::req_t kind,
                                          input logic [sthc_pkg::LINE_W-1:0] line,
                                          input logic [sthc_pkg::POINT_W-1:0] point,
                                          input logic [sthc_pkg::LEVEL_W-1:0] level,
                                          input logic last);
        plan_row_t row;
        row = '0;
        row.rq.kind = kind;
        row.rq.line = line;
        row.rq.point = point;
        row.rq.level = level;
        row.rq.last = last;
        return row;
    endfunction

    function automatic plan_row_t checked_row(input sthc_pkg::req_t kind,
                                              input logic [sthc_pkg::LINE_W-1:0] line,
                                              input logic [sthc_pkg::POINT_W-1:0] point,
                                              input logic [sthc_pkg::LEVEL_W-1:0] level,
                                              input logic last, input logic hit,
                                              input logic [1:0] exceeded,
                                              input logic [sthc_pkg::HIT_COUNT_W-1:0] count,
                                              input logic [sthc_pkg::SWEEP_W-1:0] sweeps);
        plan_row_t row;
        row = req_row(kind, line, point, level, last);
        row.golden_on = 1'b1;
        row.golden.hit = hit;
        row.golden.exceeded = exceeded;
        row.golden.count = count;
        row.golden.sweeps = sweeps;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [2:0] en, input logic and_on);
        plan_row_t row;
        row = '0;
        row.cfg_row = 1'b1;
        row.en = en;
        row.and_on = and_on;
        return row;
    endfunction

    // Appends one row to the directed plan.
    function automatic void plan_add(input plan_row_t row);
        directed_plan.insert(directed_plan.size(), row);
    endfunction

    // Mostly points in the current hot window, so counters build up.
    function automatic logic [sthc_pkg::POINT_W-1:0] pick_point();
        if ($urandom_range(0, 3) == 0)
            return sthc_pkg::POINT_W'($urandom());
        return hot_base + sthc_pkg::POINT_W'($urandom_range(0, 31));
    endfunction

    // Levels cluster around the stored thresholds, with extremes and noise.
    function automatic logic [sthc_pkg::LEVEL_W-1:0] pick_level(
        input logic [sthc_pkg::POINT_W-1:0] point);
        case ($urandom_range(0, 5))
            0: return sthc_pkg::LEVEL_W'($urandom());
            1: return 16'h7FFF;
            2: return 16'h8000;
            default: return thr_lines[$urandom_range(0, sthc_pkg::LINES_DEF - 1)][point]
                            + sthc_pkg::LEVEL_W'($urandom_range(0, 4)) - 16'd2;
        endcase
    endfunction

    task automatic record_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Presents one request, waits for its handshake and books the result.
    task automatic send_request(input plan_row_t row, input bit may_idle);
        int gap;
        int r;
        occ_result_t want;
        gap = 0;
        if (may_idle)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else if (r < 98)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.rq[31:0];
        s_tlast  <= row.rq.last;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        items_counted++;
        if (row.rq.kind == sthc_pkg::REQ_CLEAR)
            clears_sent++;
        want = predict_occupancy(row.rq);
        expected_results.insert(expected_results.size(), row.golden_on ? row.golden : want);
    endtask

    // Lets every outstanding result drain and any clearing pass finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
    endtask

    // Writes both registers on consecutive edges.
    task automatic set_config(input logic [2:0] en, input logic and_on);
        cfg_we    <= 1'b1;
        cfg_index <= sthc_pkg::CFG_LINE_ENABLE;
        cfg_data  <= en;
        @(posedge clk);
        cfg_index <= sthc_pkg::CFG_AND_LOGIC;
        cfg_data  <= {2'b00, and_on};
        @(posedge clk);
        cfg_we    <= 1'b0;
        en_mask  = en;
        and_mode = and_on;
        settings_applied++;
    endtask

    // Random traffic until the phase has its share of requests.
    task automatic run_phase(input int quota);
        int start_count;
        int r;
        int n;
        bit steady;
        bit broken;
        logic [sthc_pkg::POINT_W-1:0] pt;
        logic [sthc_pkg::LINE_W-1:0] ln;
        start_count = items_counted;
        while (items_counted - start_count < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                // A sweep over neighbouring points; some are cut or flagged wrongly.
                n = $urandom_range(3, 20);
                steady = ($urandom_range(0, 3) == 0);
                broken = ($urandom_range(0, 4) == 0);
                pt = hot_base + sthc_pkg::POINT_W'($urandom_range(0, 31));
                for (int k = 0; k < n; k++)
                begin
                    send_request(req_row(sthc_pkg::REQ_SAMPLE,
                                         sthc_pkg::LINE_W'($urandom()), pt, pick_level(pt),
                                         broken ? ($urandom_range(0, 7) == 0) : (k == n - 1)),
                                 !steady);
                    pt = pt + sthc_pkg::POINT_W'($urandom_range(0, 1));
                end
            end
            else if (r < 80)
            begin
                ln = ($urandom_range(0, 9) == 0) ? 2'd3
                                                 : sthc_pkg::LINE_W'($urandom_range(0, 2));
                pt = pick_point();
                send_request(req_row(sthc_pkg::REQ_LOAD, ln, pt, pick_level(pt),
                                     1'($urandom_range(0, 1))), 1'b1);
            end
            else if (r < 90)
            begin
                send_request(req_row(sthc_pkg::REQ_READ, sthc_pkg::LINE_W'($urandom()),
                                     pick_point(), sthc_pkg::LEVEL_W'($urandom()),
                                     1'($urandom_range(0, 1))), 1'b1);
            end
            else if (r < 92 && clears_left > 0)
            begin
                clears_left--;
                send_request(req_row(sthc_pkg::REQ_CLEAR, sthc_pkg::LINE_W'($urandom()),
                                     sthc_pkg::POINT_W'($urandom()),
                                     sthc_pkg::LEVEL_W'($urandom()),
                                     1'($urandom_range(0, 1))), 1'b1);
            end
            else
            begin
                // Stray sample anywhere in the spectrum.
                send_request(req_row(sthc_pkg::REQ_SAMPLE, sthc_pkg::LINE_W'($urandom()),
                                     sthc_pkg::POINT_W'($urandom()),
                                     sthc_pkg::LEVEL_W'($urandom()),
                                     1'($urandom_range(0, 1))), 1'b1);
            end
        end
    endtask

    // Result side: ready in runs of random length with gaps between them.
    initial
    begin
        int on_len;
        int off_len;
        int r;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 8);
            r = $urandom_range(0, 99);
            if (r < 50)
                off_len = 0;
            else if (r < 90)
                off_len = $urandom_range(1, 3);
            else
                off_len = $urandom_range(10, 40);
            m_tready <= 1'b1;
            repeat (on_len) @(posedge clk);
            if (off_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (off_len) @(posedge clk);
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        occ_result_t got;
        occ_result_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got = m_tdata[50:0];
            if (expected_results.size() == 0)
            begin
                record_failure($sformatf({"Unexpected result: hit=%0d exceeded=%0d ",
                                          "count=%0d sweeps=%0d"},
                                         got.hit, got.exceeded, got.count, got.sweeps));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    record_failure($sformatf({"Mismatch on result %0d: expected hit=%0d ",
                                              "exceeded=%0d count=%0d sweeps=%0d, got hit=%0d ",
                                              "exceeded=%0d count=%0d sweeps=%0d"},
                                             results_checked, want.hit, want.exceeded,
                                             want.count, want.sweeps, got.hit, got.exceeded,
                                             got.count, got.sweeps));
            end
            results_checked++;
        end
    end

    // Main sequence.
    initial
    begin
        logic [2:0] en;
        logic       an;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= sthc_pkg::CFG_LINE_ENABLE;
        cfg_data  <= '0;

        fail_count = 0;
        results_checked = 0;
        items_counted = 0;
        clears_sent = 0;
        clears_left = MAX_CLEARS;
        settings_applied = 0;
        hot_base = '0;
        foreach (thr_lines[l, p])
            thr_lines[l][p] = sthc_pkg::THRESH_RESET;
        foreach (hit_counts[p])
            hit_counts[p] = '0;
        sweep_total = '0;
        en_mask = 3'd0;
        and_mode = 1'b0;

        // Directed plan. Results typed in are those visible without working.
        plan_add(checked_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd0, 16'h7FFF, 1'b1,
                             1'b0, 2'd0, 16'd0, 32'd0));
        plan_add(checked_row(sthc_pkg::REQ_READ, 2'd0, 12'd4095, 16'd0, 1'b0,
                             1'b0, 2'd0, 16'd0, 32'd0));
        plan_add(checked_row(sthc_pkg::REQ_LOAD, 2'd3, 12'd5, 16'h8000, 1'b0,
                             1'b0, 2'd0, 16'd0, 32'd0));
        plan_add(cfg_row(3'd1, 1'b0));
        plan_add(checked_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd5, 16'd1600, 1'b0,
                             1'b0, 2'd0, 16'd0, 32'd0));
        plan_add(checked_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd5, 16'd1601, 1'b0,
                             1'b1, 2'd1, 16'd1, 32'd0));
        plan_add(checked_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd5, 16'h7FFF, 1'b1,
                             1'b1, 2'd1, 16'd2, 32'd1));
        plan_add(checked_row(sthc_pkg::REQ_LOAD, 2'd0, 12'd10, 16'h8000, 1'b0,
                             1'b0, 2'd0, 16'd0, 32'd1));
        plan_add(checked_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd10, 16'h8000, 1'b0,
                             1'b0, 2'd0, 16'd0, 32'd1));
        plan_add(checked_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd10, 16'h8001, 1'b1,
                             1'b1, 2'd1, 16'd1, 32'd2));
        plan_add(req_row(sthc_pkg::REQ_LOAD, 2'd1, 12'd10, 16'h7FFF, 1'b0));
        plan_add(req_row(sthc_pkg::REQ_LOAD, 2'd2, 12'd10, 16'd0, 1'b0));
        plan_add(cfg_row(3'd7, 1'b1));
        plan_add(req_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd10, 16'd100, 1'b0));
        plan_add(req_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd10, 16'h7FFF, 1'b0));
        plan_add(cfg_row(3'd7, 1'b0));
        plan_add(req_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd10, 16'd100, 1'b0));
        plan_add(req_row(sthc_pkg::REQ_LOAD, 2'd1, 12'd10, 16'hFFFF, 1'b1));
        plan_add(req_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd10, 16'd0, 1'b0));
        plan_add(cfg_row(3'd6, 1'b1));
        plan_add(req_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd10, 16'd1, 1'b1));
        plan_add(req_row(sthc_pkg::REQ_READ, 2'd0, 12'd10, 16'd0, 1'b0));
        plan_add(checked_row(sthc_pkg::REQ_CLEAR, 2'd0, 12'd10, 16'd0, 1'b0,
                             1'b0, 2'd0, 16'd0, 32'd0));
        plan_add(checked_row(sthc_pkg::REQ_READ, 2'd0, 12'd5, 16'd0, 1'b0,
                             1'b0, 2'd0, 16'd0, 32'd0));
        plan_add(cfg_row(3'd4, 1'b1));
        plan_add(req_row(sthc_pkg::REQ_SAMPLE, 2'd0, 12'd5, 16'd1601, 1'b1));
        plan_add(req_row(sthc_pkg::REQ_SAMPLE, 2'd3, 12'd4095, 16'h7FFF, 1'b0));
        plan_add(req_row(sthc_pkg::REQ_READ, 2'd0, 12'd4095, 16'd0, 1'b0));

        // Reset; after its release the block runs its clearing pass.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].cfg_row)
            begin
                settle();
                set_config(directed_plan[i].en, directed_plan[i].and_on);
            end
            else
            begin
                send_request(directed_plan[i], 1'b1);
            end
        end

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 6)
            begin
                en = fixed_en[p];
                an = fixed_and[p];
            end
            else
            begin
                en = 3'($urandom_range(0, 7));
                an = 1'($urandom_range(0, 1));
            end
            settle();
            set_config(en, an);
            hot_base = sthc_pkg::POINT_W'($urandom());
            run_phase(PHASE_ITEMS);
        end
        settle();

        $display("Covered %0d requests, %0d of them clears, under %0d register settings;",
                 items_counted, clears_sent, settings_applied);
        $display("%0d results checked against the predicted occupancy state.",
                 results_checked);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sthc_pkg.sv
hw/rtl/sthc_ram.sv
hw/rtl/sthc_sweep.sv
hw/rtl/sthc_eval.sv
hw/rtl/spectrum_threshold_hit_counter.sv
test/tb_spectrum_threshold_hit_counter.sv
